[sv/kat_pkg.sv]
// kat_pkg: shared sizes, operation and status codes, record layout and
// character trimming for the keyed account table
// no dependencies
package kat_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_BYTES   = 8;
	localparam int PASS_BYTES  = 8;

	localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int WORD_W   = 64;
	localparam int STATE_W  = 8;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 6;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [STATE_W-1:0]  acst_t;
	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [SLOT_W-1:0]   slot_t;

	localparam idx_t LAST_IDX = idx_t'(TABLE_DEPTH - 1);

	// operation codes
	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_LOOKUP = 2'd1;
	localparam op_t OP_CLEAR  = 2'd2;

	// result status codes
	localparam status_t ST_INSERTED  = 3'd0;
	localparam status_t ST_EXISTED   = 3'd1;
	localparam status_t ST_FULL      = 3'd2;
	localparam status_t ST_FOUND     = 3'd3;
	localparam status_t ST_NOT_FOUND = 3'd4;
	localparam status_t ST_INVALID   = 3'd5;
	localparam status_t ST_CLEARED   = 3'd6;

	// one stored record
	typedef struct packed {
		word_t key;
		word_t pwd;
		acst_t acst;
	} rec_t;

	// keep the top nbytes characters up to the first zero byte
	function automatic word_t trim_chars(input word_t w, input int unsigned nbytes);
		word_t kept;
		logic  stop;
		kept = '0;
		stop = 1'b0;
		for (int pos = 0; pos < 8; pos++) begin
			if (pos >= nbytes || w[63-8*pos -: 8] == 8'h00)
				stop = 1'b1;
			if (!stop)
				kept[63-8*pos -: 8] = w[63-8*pos -: 8];
		end
		return kept;
	endfunction

endpackage

[sv/keyed_account_table_unit.sv]
// keyed_account_table_unit: table of keyed account records with insert,
// lookup and clear, records held in one synchronous memory
// depends on kat_pkg
//
//  channel | valid     | stall     | beat fields
//  --------+-----------+-----------+-------------------------------------------
//  request | req_valid | req_stall | operation, key, password, account_state
//  result  | rsp_valid | rsp_stall | status, slot_index, found_password,
//          |           |           | found_state, table_full
//
// one request at a time; insert and lookup scan the memory
// one slot per cycle, ending early when the key is hit; clear and
// invalid keys go straight to the result without a scan
// reset empties the table at once through the per-slot valid flops
// a finished result sits in the output register; the next request is taken
// while it waits, and only a second finished result waits for it to drain
module keyed_account_table_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [kat_pkg::OP_W-1:0]     operation,
	input  logic [kat_pkg::WORD_W-1:0]   key,
	input  logic [kat_pkg::WORD_W-1:0]   password,
	input  logic [kat_pkg::STATE_W-1:0]  account_state,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic [kat_pkg::STATUS_W-1:0] status,
	output logic [kat_pkg::SLOT_W-1:0]   slot_index,
	output logic [kat_pkg::WORD_W-1:0]   found_password,
	output logic [kat_pkg::STATE_W-1:0]  found_state,
	output logic                      table_full
);
	import kat_pkg::*;

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;

	// request held for the whole scan
	op_t   op_q;
	word_t key_q;
	word_t pwd_q;
	acst_t acst_q;

	// record memory and its valid flops
	rec_t                   slot_mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] slot_valid_q;

	// read issue side
	idx_t rd_idx_q;
	logic issue_done_q;

	// read data side, registered from the issue side
	logic rd_vld_s1;
	idx_t rd_idx_s1;
	rec_t rd_data_s1;

	// first empty slot seen so far
	logic free_found_q;
	idx_t free_idx_q;

	// finished result waiting for the output register
	status_t res_status_q;
	slot_t   res_slot_q;
	word_t   res_pwd_q;
	acst_t   res_acst_q;

	// output register
	logic    rsp_valid_q;
	status_t status_q;
	slot_t   slot_q;
	word_t   fpwd_q;
	acst_t   facst_q;
	logic    full_q;

	logic  req_acc;
	word_t req_key_trim;
	logic  issue;
	logic  s1_vbit;
	logic  s1_match;
	logic  s1_free;
	logic  s1_last;
	logic  scan_end;
	logic  have_free;
	idx_t  free_sel;
	logic  mem_we;
	logic  out_load;

	assign req_stall    = (state_q != S_IDLE);
	assign req_acc      = req_valid && !req_stall;
	assign req_key_trim = trim_chars(key, KEY_BYTES);

	assign issue = (state_q == S_SCAN) && !issue_done_q;

	// compare stage on the word that came back from the memory
	assign s1_vbit   = slot_valid_q[rd_idx_s1];
	assign s1_match  = rd_vld_s1 && s1_vbit && (rd_data_s1.key == key_q);
	assign s1_free   = rd_vld_s1 && !s1_vbit;
	assign s1_last   = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
	assign scan_end  = (state_q == S_SCAN) && (s1_match || s1_last);
	assign have_free = free_found_q || s1_free;
	assign free_sel  = free_found_q ? free_idx_q : rd_idx_s1;

	// insert lands in the lowest empty slot once the whole table missed
	assign mem_we = scan_end && !s1_match && (op_q == OP_INSERT) && have_free;

	assign out_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// memory: one read and one write port, read data registered
	always_ff @(posedge clk) begin
		if (issue)
			rd_data_s1 <= slot_mem_q[rd_idx_q];
		if (mem_we)
			slot_mem_q[free_sel] <= '{key: key_q, pwd: pwd_q, acst: acst_q};
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue && rd_idx_q == LAST_IDX)
				issue_done_q <= 1'b1;

			if (state_q == S_SCAN && s1_free && !free_found_q)
				free_found_q <= 1'b1;

			if (mem_we)
				slot_valid_q[free_sel] <= 1'b1;

			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						issue_done_q <= 1'b0;
						free_found_q <= 1'b0;
						if (operation == OP_CLEAR) begin
							slot_valid_q <= '0;
							state_q      <= S_DONE;
						end else if (req_key_trim == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_end)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// request capture, scan pointers and result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q     <= operation;
			key_q    <= req_key_trim;
			pwd_q    <= trim_chars(password, PASS_BYTES);
			acst_q   <= account_state;
			rd_idx_q <= '0;
			res_slot_q <= '0;
			res_pwd_q  <= '0;
			res_acst_q <= '0;
			if (operation == OP_CLEAR)
				res_status_q <= ST_CLEARED;
			else
				res_status_q <= ST_INVALID;
		end

		if (issue)
			rd_idx_q <= idx_t'(rd_idx_q + 1'b1);
		rd_idx_s1 <= rd_idx_q;

		if (state_q == S_SCAN && s1_free && !free_found_q)
			free_idx_q <= rd_idx_s1;

		if (scan_end) begin
			res_slot_q <= '0;
			res_pwd_q  <= '0;
			res_acst_q <= '0;
			if (s1_match) begin
				res_slot_q <= slot_t'(rd_idx_s1);
				if (op_q == OP_INSERT) begin
					res_status_q <= ST_EXISTED;
				end else begin
					res_status_q <= ST_FOUND;
					res_pwd_q    <= rd_data_s1.pwd;
					res_acst_q   <= rd_data_s1.acst;
				end
			end else if (op_q != OP_INSERT) begin
				res_status_q <= ST_NOT_FOUND;
			end else if (have_free) begin
				res_status_q <= ST_INSERTED;
				res_slot_q   <= slot_t'(free_sel);
			end else begin
				res_status_q <= ST_FULL;
			end
		end

		// full flag taken after the table update has settled
		if (out_load) begin
			status_q <= res_status_q;
			slot_q   <= res_slot_q;
			fpwd_q   <= res_pwd_q;
			facst_q  <= res_acst_q;
			full_q   <= &slot_valid_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign slot_index     = slot_q;
	assign found_password = fpwd_q;
	assign found_state    = facst_q;
	assign table_full     = full_q;

endmodule

[sv/kat_checker.sv]
// kat_checker: port-level checks on keyed_account_table_unit, bound to it
// depends on kat_pkg and keyed_account_table_unit
module kat_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [kat_pkg::STATUS_W-1:0]  status,
	input logic [kat_pkg::SLOT_W-1:0]    slot_index,
	input logic [kat_pkg::WORD_W-1:0]    found_password,
	input logic [kat_pkg::STATE_W-1:0]   found_state,
	input logic                          table_full
);
	import kat_pkg::*;

	// one request at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot_index)
			&& $stable(found_password) && $stable(found_state) && $stable(table_full))
		else $error("stalled result changed");

	// only a found record carries password and state
	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_FOUND |-> found_password == '0 && found_state == '0)
		else $error("data on a result that found nothing");

	// a slot number only comes with inserted, existed or found
	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL || status == ST_NOT_FOUND
			|| status == ST_INVALID || status == ST_CLEARED) |-> slot_index == '0)
		else $error("slot number on a result without a slot");

	// a full report raises the full flag, a clear leaves it low
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL || (status == ST_CLEARED && TABLE_DEPTH > 0))
			|-> table_full == (status == ST_FULL))
		else $error("full flag disagrees with status");

endmodule

bind keyed_account_table_unit kat_checker u_kat_checker (.*);

[verif/tb_keyed_account_table_unit.sv]
// tb_keyed_account_table_unit: self-checking bench for the keyed account table,
// a directed stimulus table followed by phased random requests
// depends on kat_pkg and keyed_account_table_unit
`timescale 1ns / 1ps

module tb_keyed_account_table_unit;
	import kat_pkg::*;

	// spare operation code, served as a lookup
	localparam op_t OP_SPARE = 2'd3;

	localparam int POOL_SIZE    = 96;
	localparam int TOTAL_BEATS  = 1375;
	localparam int QUIET_FIRST  = 420;
	localparam int QUIET_LAST   = 720;
	localparam int SETTLE_CYCLES = 80;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		status_t status;
		slot_t   slot;
		word_t   pwd;
		acst_t   acst;
		logic    full;
	} result_t;

	typedef struct {
		op_t     op;
		word_t   key;
		word_t   pwd;
		acst_t   acst;
		bit      fixed;
		result_t result;
	} dir_row_t;

	// dut ports
	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_stall;
	op_t     operation = OP_INSERT;
	word_t   key = '0;
	word_t   password = '0;
	acst_t   account_state = '0;
	logic    rsp_valid;
	logic    rsp_stall = 1'b0;
	status_t status;
	slot_t   slot_index;
	word_t   found_password;
	acst_t   found_state;
	logic    table_full;

	// shadow copy of the account table
	bit [TABLE_DEPTH-1:0] shadow_valid;
	word_t                shadow_key [TABLE_DEPTH];
	word_t                shadow_pwd [TABLE_DEPTH];
	acst_t                shadow_acst [TABLE_DEPTH];

	result_t  pending_results [$];
	dir_row_t directed_rows [$];
	word_t    pool_key [POOL_SIZE];
	int       pool_len [POOL_SIZE];

	int  beats_sent = 0;
	int  mismatch_count = 0;
	int  status_seen [8];
	int  stall_cycles = 0;
	bit  no_gaps = 1'b0;
	int  fill_ptr = 0;
	bit  drained_once = 1'b0;

	keyed_account_table_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.operation      (operation),
		.key            (key),
		.password       (password),
		.account_state  (account_state),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.slot_index     (slot_index),
		.found_password (found_password),
		.found_state    (found_state),
		.table_full     (table_full)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// keep the leading characters of a word up to the first nul byte
	function automatic word_t cut_at_nul(input word_t w, input int nbytes);
		int n;
		n = 0;
		while (n < nbytes && n < 8 && w[63-8*n -: 8] != 8'h00)
			n++;
		if (n == 0)
			return '0;
		return w & ({64{1'b1}} << (64 - 8 * n));
	endfunction

	// apply one request to the shadow table and return what the dut must answer
	function automatic result_t account_table_apply(input op_t op, input word_t k,
			input word_t pw, input acst_t st);
		result_t r;
		word_t   tk;
		int      hit;
		r = '0;
		r.status = ST_NOT_FOUND;
		tk = cut_at_nul(k, KEY_BYTES);
		hit = -1;
		for (int s = TABLE_DEPTH - 1; s >= 0; s--)
			if (shadow_valid[s] && shadow_key[s] == tk)
				hit = s;
		if (op == OP_CLEAR) begin
			shadow_valid = '0;
			r.status = ST_CLEARED;
		end else if (tk == '0) begin
			r.status = ST_INVALID;
		end else if (op == OP_INSERT) begin
			if (hit >= 0) begin
				r.status = ST_EXISTED;
				r.slot = slot_t'(hit);
			end else begin
				r.status = ST_FULL;
				for (int s = 0; s < TABLE_DEPTH; s++) begin
					if (r.status == ST_FULL && !shadow_valid[s]) begin
						shadow_valid[s] = 1'b1;
						shadow_key[s] = tk;
						shadow_pwd[s] = cut_at_nul(pw, PASS_BYTES);
						shadow_acst[s] = st;
						r.status = ST_INSERTED;
						r.slot = slot_t'(s);
					end
				end
			end
		end else if (hit >= 0) begin
			// lookup, spare code included
			r.status = ST_FOUND;
			r.slot = slot_t'(hit);
			r.pwd = shadow_pwd[hit];
			r.acst = shadow_acst[hit];
		end
		r.full = &shadow_valid;
		return r;
	endfunction

	// a zero-filled answer, for rows whose outcome is plain
	function automatic result_t plain_result(input status_t s);
		result_t r;
		r = '0;
		r.status = s;
		return r;
	endfunction

	function automatic void add_row(input op_t op, input word_t k, input word_t pw,
			input acst_t st);
		dir_row_t row;
		row.op = op;
		row.key = k;
		row.pwd = pw;
		row.acst = st;
		row.fixed = 1'b0;
		row.result = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_fixed(input op_t op, input word_t k, input word_t pw,
			input acst_t st, input status_t s);
		add_row(op, k, pw, st);
		directed_rows[directed_rows.size()-1].fixed = 1'b1;
		directed_rows[directed_rows.size()-1].result = plain_result(s);
	endfunction

	function automatic word_t random_word();
		return {$urandom, $urandom};
	endfunction

	// random password, now and then cut short by a nul byte
	function automatic word_t random_password();
		word_t pw;
		pw = random_word();
		if ($urandom_range(0, 3) == 0)
			pw[63-8*$urandom_range(0, 7) -: 8] = 8'h00;
		return pw;
	endfunction

	// a pool key, sometimes with junk after its terminating nul
	function automatic word_t pool_variant(input int i);
		word_t w;
		w = pool_key[i];
		if (pool_len[i] < 7 && $urandom_range(0, 2) == 0)
			for (int p = pool_len[i] + 1; p < 8; p++)
				w[63-8*p -: 8] = 8'($urandom);
		return w;
	endfunction

	// first byte is unique per entry, so trimmed pool keys never collide
	function automatic void build_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_len[i] = $urandom_range(1, 8);
			pool_key[i] = '0;
			pool_key[i][63 -: 8] = 8'(i + 1 + 128 * $urandom_range(0, 1));
			for (int p = 1; p < pool_len[i]; p++)
				pool_key[i][63-8*p -: 8] = 8'($urandom_range(1, 255));
		end
	endfunction

	// present one request beat and log its expected answer once taken
	task automatic drive_request(input op_t op, input word_t k, input word_t pw,
			input acst_t st);
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < 7) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		key <= k;
		password <= pw;
		account_state <= st;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_results.push_back(account_table_apply(op, k, pw, st));
		beats_sent++;
		no_gaps = (beats_sent >= QUIET_FIRST && beats_sent < QUIET_LAST);
	endtask

	// hold the request side off until every answer is back
	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		drained_once = 1'b1;
	endtask

	// result side back-pressure
	always @(negedge clk) begin
		rsp_stall <= !no_gaps && $urandom_range(0, 99) < 7;
	end

	// result checker
	always @(posedge clk) begin : result_check
		result_t want;
		result_t got;
		got = '{status, slot_index, found_password, found_state, table_full};
		if (arst_n && rsp_valid && rsp_stall)
			stall_cycles++;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("unexpected result beat: status %0d slot %0d", status, slot_index);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				status_seen[want.status]++;
				if (got.status != want.status || got.slot != want.slot
						|| got.pwd != want.pwd || got.acst != want.acst
						|| got.full != want.full) begin
					if (mismatch_count < REPORT_LIMIT) begin
						$display("mismatch at %0t: expected st %0d slot %0d pwd %h acst %h full %b",
							$realtime, want.status, want.slot, want.pwd, want.acst, want.full);
						$display("  got st %0d slot %0d pwd %h acst %h full %b",
							got.status, got.slot, got.pwd, got.acst, got.full);
					end
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		int n;
		int r;
		shadow_valid = '0;
		for (int s = 0; s < 8; s++)
			status_seen[s] = 0;
		build_pool();

		// plain rows carry their answer, the rest go through the shadow table
		add_fixed(OP_LOOKUP, 64'h414C_4943_4500_0000, '0, 8'h00, ST_NOT_FOUND);
		add_fixed(OP_INSERT, 64'h0, {64{1'b1}}, 8'hFF, ST_INVALID);
		add_fixed(OP_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, '0, 8'h00, ST_INVALID);
		add_fixed(OP_SPARE, 64'h0012_3456_789A_BCDE, '0, 8'h00, ST_INVALID);
		add_row(OP_INSERT, 64'h414C_4943_4500_0000, 64'h5345_4352_4554_0000, 8'h5A);
		add_row(OP_INSERT, 64'h414C_4943_4500_7F01, 64'h1234_5678_9ABC_DEF0, 8'h11);
		add_row(OP_LOOKUP, 64'h414C_4943_4500_0000, '0, 8'h00);
		add_row(OP_INSERT, {64{1'b1}}, {64{1'b1}}, 8'hFF);
		add_row(OP_LOOKUP, {64{1'b1}}, '0, 8'h00);
		add_row(OP_INSERT, 64'h0100_0000_0000_0000, '0, 8'h00);
		add_row(OP_LOOKUP, 64'h0100_0000_0000_0000, {64{1'b1}}, 8'hFF);
		add_row(OP_INSERT, 64'h4142_006A_756E_6B00, 64'h5057_0078_797A_0000, 8'h80);
		add_row(OP_LOOKUP, 64'h4142_0000_0000_0000, '0, 8'h00);
		add_row(OP_SPARE, 64'h4142_0011_2233_4455, '0, 8'h00);
		add_row(OP_LOOKUP, 64'h4341_524F_4C00_0000, '0, 8'h00);
		add_row(OP_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 64'h8080_8080_8080_8080, 8'h01);
		add_fixed(OP_CLEAR, 64'hDEAD_BEEF_0BAD_F00D, 64'h55AA_55AA_55AA_55AA, 8'hA5,
			ST_CLEARED);
		add_fixed(OP_LOOKUP, 64'h414C_4943_4500_0000, '0, 8'h00, ST_NOT_FOUND);
		add_row(OP_INSERT, 64'h424F_4200_0000_0000, 64'h5057_0000_0000_0000, 8'h33);
		add_row(OP_LOOKUP, 64'h424F_4200_5800_0000, '0, 8'h00);
		add_fixed(OP_CLEAR, 64'h0, '0, 8'h00, ST_CLEARED);
		add_fixed(OP_LOOKUP, 64'h424F_4200_0000_0000, '0, 8'h00, ST_NOT_FOUND);

		// reset, once
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			drive_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pwd,
				directed_rows[i].acst);
			if (directed_rows[i].fixed)
				pending_results[pending_results.size()-1] = directed_rows[i].result;
		end
		drain_results();

		// random phases: fill runs that drive the table toward full, and mixed traffic
		while (beats_sent < TOTAL_BEATS) begin
			if ($urandom_range(0, 1) == 1) begin
				if ($urandom_range(0, 1) == 1)
					drive_request(OP_CLEAR, random_word(), random_word(), 8'($urandom));
				n = $urandom_range(50, 75);
				repeat (n) begin
					if ($urandom_range(0, 9) < 8) begin
						drive_request(OP_INSERT, pool_variant(fill_ptr % POOL_SIZE),
							random_password(), 8'($urandom));
						fill_ptr++;
					end else begin
						drive_request(OP_LOOKUP, pool_variant($urandom_range(0, POOL_SIZE - 1)),
							random_word(), 8'($urandom));
					end
				end
			end else begin
				n = $urandom_range(20, 40);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 40)
						drive_request(OP_INSERT, pool_variant($urandom_range(0, POOL_SIZE - 1)),
							random_password(), 8'($urandom));
					else if (r < 80)
						drive_request(OP_LOOKUP, pool_variant($urandom_range(0, POOL_SIZE - 1)),
							random_word(), 8'($urandom));
					else if (r < 85)
						drive_request(OP_LOOKUP, random_word(), random_word(), 8'($urandom));
					else if (r < 89)
						drive_request(OP_INSERT, random_word(), random_password(), 8'($urandom));
					else if (r < 93)
						// empty key through any non-clear code
						drive_request(op_t'($urandom_range(0, 1) ? OP_SPARE
							: op_t'($urandom_range(0, 1))),
							{8'h00, 56'(random_word())}, random_word(), 8'($urandom));
					else if (r < 97)
						drive_request(OP_SPARE, pool_variant($urandom_range(0, POOL_SIZE - 1)),
							random_word(), 8'($urandom));
					else
						drive_request(OP_CLEAR, random_word(), random_word(), 8'($urandom));
				end
			end
			if (!drained_once || $urandom_range(0, 3) == 0)
				drain_results();
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d requests: %0d inserted, %0d existed, %0d full, %0d found",
			beats_sent, status_seen[ST_INSERTED], status_seen[ST_EXISTED],
			status_seen[ST_FULL], status_seen[ST_FOUND]);
		$display("  %0d not found, %0d empty key, %0d cleared, %0d stalled result cycles",
			status_seen[ST_NOT_FOUND], status_seen[ST_INVALID], status_seen[ST_CLEARED],
			stall_cycles);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
